// ===== rtl/mme_pkg.sv =====
// Package for the matrix multiply engine: item types, mode and register codes,
// and the fixed field widths and defaults. No dependencies.
`default_nettype none

package mme_pkg;

  // Fixed field widths of the item, result and cfg channels.
  localparam int CFG_WIDTH     = 4;
  localparam int IDX_WIDTH     = 3;
  localparam int IN_ELEM_WIDTH = 16;
  localparam int PROD_WIDTH    = 36;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;

  // Reset value of every size register.
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 4'd3;

  // Operation carried by an input item; the fourth code is ignored.
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_INNER = 2'd1,
    REG_COLS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    mode_t                             mode;
    logic [IDX_WIDTH-1:0]              row_index;
    logic [IDX_WIDTH-1:0]              col_index;
    logic signed [IN_ELEM_WIDTH-1:0]   element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [PROD_WIDTH-1:0]      product_value;
    logic [IDX_WIDTH-1:0]              out_row;
    logic [IDX_WIDTH-1:0]              out_col;
    logic                              last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/matrix_multiply_engine_top.sv =====
// Top level of the matrix multiply engine: element stores, index sequencer,
// multiply-accumulate pipeline and result register. Depends on mme_pkg.
//
// Usage:
//   The item channel (item_valid, item_stall, item) carries load and compute
//   items. A load of A or B writes one element; loads whose row or
//   column lie outside the configured sizes are dropped. A compute item walks
//   the product in row-major order and sends one result item per element on
//   the result channel (result_valid, result_stall, result), with last set on
//   the final element.
//   Each product element takes one multiply-accumulate per step of the inner
//   dimension, one per cycle while the receiver does not stall, limited by the
//   single read port of each element store. A step passes the read registers,
//   the multiply register and the accumulator; the result register takes the
//   final sum of an element. Input items are stalled while a run is still
//   reading the stores; loads may follow once the last read issued.
//   When the receiver stalls, the pipeline and the store reads freeze and
//   resume with nothing lost. Size registers are written on the cfg channel
//   while the block is idle; sizes of 0 act as 1, sizes above MAX_DIM as MAX_DIM.
//   Reset clears the control state and sets all sizes to 3. Store contents
//   are undefined until written.
`default_nettype none

module matrix_multiply_engine_top
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire in_item_t             item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_item_t                 result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM);
  localparam int MW    = 2 * ELEM_WIDTH;
  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

  // Clamp a size register to the range 1..MAX_DIM.
  function automatic logic [CFG_WIDTH-1:0] eff_size(input logic [CFG_WIDTH-1:0] r);
    logic [CFG_WIDTH-1:0] s;
    s = r;
    if (r == '0) s = CFG_WIDTH'(1);
    else if (int'(r) > MAX_DIM) s = CFG_WIDTH'(MAX_DIM);
    return s;
  endfunction

  // Size registers.
  logic [CFG_WIDTH-1:0] rows_of_first;
  logic [CFG_WIDTH-1:0] inner_size;
  logic [CFG_WIDTH-1:0] cols_of_second;
  logic [CFG_WIDTH-1:0] nr, nk, nc;

  assign nr = eff_size(rows_of_first);
  assign nk = eff_size(inner_size);
  assign nc = eff_size(cols_of_second);

  // Element stores.
  logic [ELEM_WIDTH-1:0] first_store  [DEPTH];
  logic [ELEM_WIDTH-1:0] second_store [DEPTH];

  // Sequencer and pipeline state.
  logic          busy;
  logic [DW-1:0] ci, cj, ck;
  logic          adv;
  logic          issue;
  logic          k_end, j_end, i_end;

  logic                  s1_valid, s1_first, s1_last, s1_final;
  logic [DW-1:0]         s1_i, s1_j;
  logic [ELEM_WIDTH-1:0] a_q, b_q;

  logic                  s2_valid, s2_first, s2_last, s2_final;
  logic [DW-1:0]         s2_i, s2_j;
  logic signed [MW-1:0]  prod_q;

  logic signed [PROD_WIDTH-1:0] acc;
  logic signed [PROD_WIDTH-1:0] sum;

  logic                  accept;
  logic [ELEM_WIDTH-1:0] elem_w;
  logic [AW-1:0]         load_addr;
  logic [AW-1:0]         addr_a, addr_b;
  logic                  load_a_ok, load_b_ok;

  // Handshakes.
  assign item_stall = busy;
  assign cfg_ready  = !busy;
  assign accept     = item_valid && !item_stall;
  assign adv        = !result_valid || !result_stall;
  assign issue      = busy && adv;

  // Load decoding.
  assign elem_w    = ELEM_WIDTH'($unsigned(item.element_value));
  assign load_addr = AW'(item.row_index) * DIM_A + AW'(item.col_index);
  assign load_a_ok = (CFG_WIDTH'(item.row_index) < nr) && (CFG_WIDTH'(item.col_index) < nk);
  assign load_b_ok = (CFG_WIDTH'(item.row_index) < nk) && (CFG_WIDTH'(item.col_index) < nc);

  // Read addresses of the current dot-product step.
  assign addr_a = AW'(ci) * DIM_A + AW'(ck);
  assign addr_b = AW'(ck) * DIM_A + AW'(cj);

  assign k_end = CFG_WIDTH'(ck) == nk - 1'b1;
  assign j_end = CFG_WIDTH'(cj) == nc - 1'b1;
  assign i_end = CFG_WIDTH'(ci) == nr - 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_first  <= CFG_RESET;
      inner_size     <= CFG_RESET;
      cols_of_second <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS:  rows_of_first  <= cfg_data;
        REG_INNER: inner_size     <= cfg_data;
        REG_COLS:  cols_of_second <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Store writes from load items.
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_LOAD_A && load_a_ok) begin
      first_store[load_addr] <= elem_w;
    end
    if (accept && item.mode == MODE_LOAD_B && load_b_ok) begin
      second_store[load_addr] <= elem_w;
    end
  end

  // Store reads, registered, one pair per dot-product step.
  always_ff @(posedge clk) begin
    if (issue) begin
      a_q <= first_store[addr_a];
      b_q <= second_store[addr_b];
    end
  end

  // Index sequencer: k innermost, then j, then i.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ci   <= '0;
      cj   <= '0;
      ck   <= '0;
    end else if (!busy) begin
      if (accept && item.mode == MODE_COMPUTE) begin
        busy <= 1'b1;
        ci   <= '0;
        cj   <= '0;
        ck   <= '0;
      end
    end else if (adv) begin
      if (!k_end) begin
        ck <= ck + 1'b1;
      end else begin
        ck <= '0;
        if (!j_end) begin
          cj <= cj + 1'b1;
        end else begin
          cj <= '0;
          if (!i_end) begin
            ci <= ci + 1'b1;
          end else begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  // Tags that travel beside the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_first <= (ck == '0);
      s1_last  <= k_end;
      s1_final <= k_end && j_end && i_end;
      s1_i     <= ci;
      s1_j     <= cj;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      prod_q   <= $signed(a_q) * $signed(b_q);
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_final <= s1_final;
      s2_i     <= s1_i;
      s2_j     <= s1_j;
    end
  end

  // Accumulate stage; a step that opens an element starts from zero.
  assign sum = (s2_first ? '0 : acc) + PROD_WIDTH'(prod_q);

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      acc <= sum;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && s2_valid && s2_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_last) begin
      result.product_value <= sum;
      result.out_row       <= IDX_WIDTH'(s2_i);
      result.out_col       <= IDX_WIDTH'(s2_j);
      result.last          <= s2_final;
    end
  end

endmodule

`default_nettype wire
